@@ rtl/core/uv_sphere_vertex_generator_core_macros.svh @@
// assertion helpers for the checker file
`ifndef UV_SPHERE_VERTEX_GENERATOR_CORE_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define UVS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define UVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/uvs_pkg.sv @@
package uvs_pkg;

  localparam int PHASE_W      = 32;
  localparam int NUM_W        = 40;
  localparam int DIV_STAGES   = 10;
  localparam int DIV_STEPS    = NUM_W / DIV_STAGES;
  localparam int LANE_STAGES  = 24;
  localparam int COMB_STAGES  = 2;
  localparam int TOTAL_STAGES = DIV_STAGES + LANE_STAGES + COMB_STAGES;

  // configuration register indexes
  localparam logic [1:0] REG_RADIUS       = 2'd0;
  localparam logic [1:0] REG_RING_COUNT   = 2'd1;
  localparam logic [1:0] REG_SECTOR_COUNT = 2'd2;

  localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;

  // signed q30 sample
  typedef logic signed [31:0] q30_t;

endpackage

@@ rtl/core/uvs_phase_div.sv @@
module uvs_phase_div import uvs_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [NUM_W-1:0]      numer,
  input  logic [7:0]            divisor,
  output logic [PHASE_W-1:0]    quotient
);

  logic [NUM_W-1:0] w_r   [DIV_STAGES];
  logic [NUM_W-1:0] w_nxt [DIV_STAGES];
  logic [7:0]       rem_r   [DIV_STAGES];
  logic [7:0]       rem_nxt [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [NUM_W-1:0] w_in;
    logic [7:0]       rem_in;

    if (i == 0) begin : g_first
      assign w_in   = numer;
      assign rem_in = 8'd0;
    end else begin : g_rest
      assign w_in   = w_r[i-1];
      assign rem_in = rem_r[i-1];
    end

    // restoring long division, quotient bits shift in from the bottom
    always_comb begin
      logic [8:0]       t;
      logic [NUM_W-1:0] w;
      logic [7:0]       rem;
      w   = w_in;
      rem = rem_in;
      for (int j = 0; j < DIV_STEPS; j++) begin
        t = {rem, w[NUM_W-1]};
        w = {w[NUM_W-2:0], 1'b0};
        if (t >= {1'b0, divisor}) begin
          rem  = 8'(t - {1'b0, divisor});
          w[0] = 1'b1;
        end else begin
          rem = t[7:0];
        end
      end
      w_nxt[i]   = w;
      rem_nxt[i] = rem;
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        w_r[i]   <= w_nxt[i];
        rem_r[i] <= rem_nxt[i];
      end
    end
  end

  assign quotient = w_r[DIV_STAGES-1][PHASE_W-1:0];

endmodule

@@ rtl/core/uvs_sine_lane.sv @@
module uvs_sine_lane import uvs_pkg::*; (
  input  logic                   clk,
  input  logic [LANE_STAGES-1:0] en,
  input  logic [PHASE_W-1:0]     phase,
  output q30_t                   sine
);

  localparam int NTERMS = 7;
  // fractional part of pi/2 in q32, the integer one is added as a shift
  localparam logic [31:0] HALFPI_FRAC = 32'h921F_B544;
  // taylor denominators and floor(2^32 / d)
  localparam logic [7:0]  DIVS   [NTERMS] = '{8'd6, 8'd20, 8'd42, 8'd72,
                                              8'd110, 8'd156, 8'd210};
  localparam logic [31:0] RECIPS [NTERMS] = '{32'd715827882, 32'd214748364,
                                              32'd102261126, 32'd59652323,
                                              32'd39045157, 32'd27531841,
                                              32'd20452225};

  typedef struct packed {
    logic               neg;
    logic [31:0]        x2;
    logic [31:0]        term;
    logic [31:0]        aux;
    logic signed [33:0] sum;
  } lane_t;

  lane_t st_r   [LANE_STAGES];
  lane_t st_nxt [LANE_STAGES];

  // fold to a quarter turn and scale to radians
  always_comb begin
    logic [30:0] u;
    logic [62:0] prod;
    st_nxt[0]     = '0;
    u             = phase[30] ? 31'h4000_0000 - {1'b0, phase[29:0]}
                              : {1'b0, phase[29:0]};
    prod          = 63'(u) * 63'(HALFPI_FRAC);
    st_nxt[0].neg  = phase[31];
    st_nxt[0].term = 32'(u) + {1'b0, prod[62:32]};
  end

  // x squared, series starts at x
  always_comb begin
    logic [63:0] sq;
    st_nxt[1]     = st_r[0];
    sq            = 64'(st_r[0].term) * 64'(st_r[0].term);
    st_nxt[1].x2  = sq[61:30];
    st_nxt[1].sum = signed'({2'b00, st_r[0].term});
  end

  for (genvar k = 0; k < NTERMS; k++) begin : g_term
    localparam int B = 2 + 3 * k;

    always_comb begin
      logic [63:0] p;
      st_nxt[B]      = st_r[B-1];
      p              = 64'(st_r[B-1].term) * 64'(st_r[B-1].x2);
      st_nxt[B].term = p[61:30];
    end

    // reciprocal estimate, at most one low
    always_comb begin
      logic [63:0] p;
      st_nxt[B+1]      = st_r[B];
      p                = 64'(st_r[B].term) * 64'(RECIPS[k]);
      st_nxt[B+1].aux  = st_r[B].term;
      st_nxt[B+1].term = p[63:32];
    end

    always_comb begin
      logic [39:0] qc;
      logic [31:0] rem;
      logic [31:0] t;
      st_nxt[B+2] = st_r[B+1];
      qc          = 40'(st_r[B+1].term) * 40'(DIVS[k]);
      rem         = st_r[B+1].aux - qc[31:0];
      t           = st_r[B+1].term + 32'(rem >= 32'(DIVS[k]));
      st_nxt[B+2].term = t;
      if (k % 2 == 0) begin
        st_nxt[B+2].sum = st_r[B+1].sum - signed'({2'b00, t});
      end else begin
        st_nxt[B+2].sum = st_r[B+1].sum + signed'({2'b00, t});
      end
    end
  end

  // clamp to [0, 1.0] and restore the sign
  always_comb begin
    logic [30:0] mag;
    st_nxt[LANE_STAGES-1] = st_r[LANE_STAGES-2];
    if (st_r[LANE_STAGES-2].sum < 0) begin
      mag = 31'd0;
    end else if (st_r[LANE_STAGES-2].sum > 34'sd1073741824) begin
      mag = 31'h4000_0000;
    end else begin
      mag = st_r[LANE_STAGES-2].sum[30:0];
    end
    st_nxt[LANE_STAGES-1].aux = st_r[LANE_STAGES-2].neg ? -{1'b0, mag} : {1'b0, mag};
  end

  for (genvar i = 0; i < LANE_STAGES; i++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign sine = signed'(st_r[LANE_STAGES-1].aux);

endmodule

@@ rtl/core/uvs_combine.sv @@
module uvs_combine import uvs_pkg::*; #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic [COMB_STAGES-1:0] en,
  input  q30_t                   sin_t,
  input  q30_t                   sin_p,
  input  q30_t                   cos_p,
  input  q30_t                   ny,
  input  logic [7:0]             ring_index,
  input  logic [7:0]             sector_index,
  input  logic [8:0]             rings,
  input  logic [8:0]             sectors,
  input  logic [15:0]            radius,
  output logic                   point_valid,
  output logic signed [16:0]     pos_first,
  output logic signed [16:0]     pos_second,
  output logic signed [16:0]     pos_third,
  output logic signed [15:0]     norm_first,
  output logic signed [15:0]     norm_second,
  output logic signed [15:0]     norm_third,
  output logic                   quad_valid,
  output logic [15:0]            corner_a,
  output logic [15:0]            corner_b,
  output logic [15:0]            corner_c,
  output logic [15:0]            corner_d
);

  localparam int SH = 30 - NORMAL_FRAC_BITS;

  function automatic logic [30:0] mag_of(input q30_t v);
    return v[31] ? 31'(-v) : v[30:0];
  endfunction

  // rounded q30 product, sign reapplied
  function automatic q30_t mul_q30(input q30_t a, input q30_t b);
    logic [61:0] p;
    logic [31:0] m;
    p = 62'(mag_of(a)) * 62'(mag_of(b));
    m = 32'((p + 62'(32'h2000_0000)) >> 30);
    return (a[31] ^ b[31]) ? signed'(-m) : signed'(m);
  endfunction

  function automatic logic [15:0] to_normal(input q30_t v);
    logic [32:0] r;
    r = ({1'b0, mag_of(v), 1'b0} + (33'd1 << SH)) >> (SH + 1);
    return v[31] ? 16'(-r) : r[15:0];
  endfunction

  function automatic logic [16:0] to_position(input q30_t v, input logic [15:0] rad);
    logic [46:0] p;
    logic [46:0] r;
    p = 47'(mag_of(v)) * 47'(rad);
    r = (p + 47'(32'h2000_0000)) >> 30;
    return v[31] ? 17'(-r) : r[16:0];
  endfunction

  q30_t       nx_r, nz_r, ny_r;
  logic [7:0] r_r, s_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      nx_r <= mul_q30(cos_p, sin_t);
      nz_r <= mul_q30(sin_p, sin_t);
      ny_r <= ny;
      r_r  <= ring_index;
      s_r  <= sector_index;
    end
  end

  logic        pv_nxt, qv_nxt;
  logic [16:0] rs_prod;
  logic [15:0] a_nxt, d_nxt;

  always_comb begin
    pv_nxt  = ({1'b0, r_r} < rings) && ({1'b0, s_r} < sectors);
    qv_nxt  = ({1'b0, r_r} < rings - 9'd1) && ({1'b0, s_r} < sectors - 9'd1);
    rs_prod = 17'(r_r) * 17'(sectors);
    a_nxt   = 16'(rs_prod + 17'(s_r));
    d_nxt   = a_nxt + 16'(sectors);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      point_valid <= pv_nxt;
      quad_valid  <= qv_nxt;
      pos_first   <= pv_nxt ? signed'(to_position(nx_r, radius)) : '0;
      pos_second  <= pv_nxt ? signed'(to_position(nz_r, radius)) : '0;
      pos_third   <= pv_nxt ? signed'(to_position(ny_r, radius)) : '0;
      norm_first  <= pv_nxt ? signed'(to_normal(nx_r)) : '0;
      norm_second <= pv_nxt ? signed'(to_normal(nz_r)) : '0;
      norm_third  <= pv_nxt ? signed'(to_normal(ny_r)) : '0;
      corner_a    <= qv_nxt ? a_nxt : '0;
      corner_b    <= qv_nxt ? a_nxt + 16'd1 : '0;
      corner_c    <= qv_nxt ? d_nxt + 16'd1 : '0;
      corner_d    <= qv_nxt ? d_nxt : '0;
    end
  end

endmodule

@@ rtl/core/uv_sphere_vertex_generator_core.sv @@
// uv sphere vertex generator: one grid point (ring, sector) in, one vertex
// out. a fully pipelined datapath of 36 register stages takes one transfer
// per cycle while the output side does not stall; the stages are the phase
// dividers (ten stages, four quotient bits each), the taylor sine lanes (24
// stages: fold, square, three per series term and the clamp) and two combine
// stages. stall from the output only halts stages that are full, so empty
// slots close up and the input keeps taking transfers while a result waits,
// until every stage is full. the user must write configuration only while
// the block is idle; the block itself does not enforce this.
module uv_sphere_vertex_generator_core import uvs_pkg::*; #(
  parameter int MAX_GRID         = 256,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_ring_index,
  input  logic [7:0]         in_sector_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_point_valid,
  output logic signed [16:0] out_pos_first,
  output logic signed [16:0] out_pos_second,
  output logic signed [16:0] out_pos_third,
  output logic signed [15:0] out_norm_first,
  output logic signed [15:0] out_norm_second,
  output logic signed [15:0] out_norm_third,
  output logic               out_quad_valid,
  output logic [15:0]        out_corner_a,
  output logic [15:0]        out_corner_b,
  output logic [15:0]        out_corner_c,
  output logic [15:0]        out_corner_d,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int SIDE_STAGES = DIV_STAGES + LANE_STAGES;

  // counts below two act as two, above the grid limit as the limit
  function automatic logic [8:0] clamp_count(input logic [8:0] c);
    if (c < 9'd2) begin
      return 9'd2;
    end
    if (c > 9'(MAX_GRID)) begin
      return 9'(MAX_GRID);
    end
    return c;
  endfunction

  // configuration registers
  logic [15:0] radius_r;
  logic [8:0]  ring_count_r, sector_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r       <= 16'd256;
      ring_count_r   <= 9'd16;
      sector_count_r <= 9'd16;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RADIUS:       radius_r       <= cfg_data;
        REG_RING_COUNT:   ring_count_r   <= cfg_data[8:0];
        REG_SECTOR_COUNT: sector_count_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic [8:0] rings, sectors;
  logic [7:0] ring_div, sector_div;

  assign rings      = clamp_count(ring_count_r);
  assign sectors    = clamp_count(sector_count_r);
  assign ring_div   = 8'(rings - 9'd1);
  assign sector_div = 8'(sectors - 9'd1);

  // stage valids and load enables; a stage loads when empty or when its
  // content moves on, which is true unless it and all stages after it hold
  // data and the output is stalled
  logic [TOTAL_STAGES-1:0] v_r, v_nxt;
  logic [TOTAL_STAGES-1:0] en;

  for (genvar i = 0; i < TOTAL_STAGES; i++) begin : g_en
    assign en[i] = !(out_stall && (&v_r[TOTAL_STAGES-1:i]));
  end

  always_comb begin
    for (int i = 0; i < TOTAL_STAGES; i++) begin
      if (i == 0) begin
        v_nxt[i] = en[i] ? in_valid : v_r[i];
      end else begin
        v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[TOTAL_STAGES-1];

  // grid point travels beside the arithmetic up to the combine stage
  logic [7:0] r_pipe_r [SIDE_STAGES];
  logic [7:0] s_pipe_r [SIDE_STAGES];

  for (genvar i = 0; i < SIDE_STAGES; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[i]) begin
        if (i == 0) begin
          r_pipe_r[i] <= in_ring_index;
          s_pipe_r[i] <= in_sector_index;
        end else begin
          r_pipe_r[i] <= r_pipe_r[(i == 0) ? 0 : i-1];
          s_pipe_r[i] <= s_pipe_r[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  // rounded phases: theta = r*2^31/(rings-1), phi = s*2^32/(sectors-1)
  logic [NUM_W-1:0]   theta_num, phi_num;
  logic [PHASE_W-1:0] theta, phi;

  assign theta_num = {1'b0, in_ring_index, 31'd0} + NUM_W'(ring_div >> 1);
  assign phi_num   = {in_sector_index, 32'd0} + NUM_W'(sector_div >> 1);

  uvs_phase_div u_theta_div (
    .clk      (clk),
    .en       (en[DIV_STAGES-1:0]),
    .numer    (theta_num),
    .divisor  (ring_div),
    .quotient (theta)
  );

  uvs_phase_div u_phi_div (
    .clk      (clk),
    .en       (en[DIV_STAGES-1:0]),
    .numer    (phi_num),
    .divisor  (sector_div),
    .quotient (phi)
  );

  // four sine lanes: sin theta, sin(theta - quarter) for y, sin phi, cos phi
  q30_t sin_t, ny, sin_p, cos_p;

  uvs_sine_lane u_sin_t (
    .clk   (clk),
    .en    (en[DIV_STAGES +: LANE_STAGES]),
    .phase (theta),
    .sine  (sin_t)
  );

  uvs_sine_lane u_ny (
    .clk   (clk),
    .en    (en[DIV_STAGES +: LANE_STAGES]),
    .phase (theta - QUARTER_TURN),
    .sine  (ny)
  );

  uvs_sine_lane u_sin_p (
    .clk   (clk),
    .en    (en[DIV_STAGES +: LANE_STAGES]),
    .phase (phi),
    .sine  (sin_p)
  );

  uvs_sine_lane u_cos_p (
    .clk   (clk),
    .en    (en[DIV_STAGES +: LANE_STAGES]),
    .phase (phi + QUARTER_TURN),
    .sine  (cos_p)
  );

  // normal products, rounding to output formats, grid checks and corners
  uvs_combine #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_combine (
    .clk          (clk),
    .en           (en[TOTAL_STAGES-1 -: COMB_STAGES]),
    .sin_t        (sin_t),
    .sin_p        (sin_p),
    .cos_p        (cos_p),
    .ny           (ny),
    .ring_index   (r_pipe_r[SIDE_STAGES-1]),
    .sector_index (s_pipe_r[SIDE_STAGES-1]),
    .rings        (rings),
    .sectors      (sectors),
    .radius       (radius_r),
    .point_valid  (out_point_valid),
    .pos_first    (out_pos_first),
    .pos_second   (out_pos_second),
    .pos_third    (out_pos_third),
    .norm_first   (out_norm_first),
    .norm_second  (out_norm_second),
    .norm_third   (out_norm_third),
    .quad_valid   (out_quad_valid),
    .corner_a     (out_corner_a),
    .corner_b     (out_corner_b),
    .corner_c     (out_corner_c),
    .corner_d     (out_corner_d)
  );

endmodule

@@ rtl/core/uvs_checker.sv @@
`include "uv_sphere_vertex_generator_core_macros.svh"

module uvs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_point_valid,
  input logic signed [16:0] out_pos_first,
  input logic signed [15:0] out_norm_third,
  input logic               out_quad_valid,
  input logic [15:0]        out_corner_a,
  input logic [15:0]        out_corner_b,
  input logic [15:0]        out_corner_c,
  input logic [15:0]        out_corner_d
);

  // a stalled result stays put
  `UVS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_corner_a) && $stable(out_pos_first) && $stable(out_norm_third), "stalled result changed")

  // a point off the grid carries no quad and no geometry
  `UVS_ASSERT_NOW(a_off_grid, out_valid && !out_point_valid, !out_quad_valid && out_pos_first == 17'sd0 && out_norm_third == 16'sd0, "off-grid point not cleared")

  // quad corners are neighbors along a ring
  `UVS_ASSERT_NOW(a_quad_corners, out_valid && out_quad_valid, out_corner_b == out_corner_a + 16'd1 && out_corner_c == out_corner_d + 16'd1, "quad corners inconsistent")

  // no quad, no corners
  `UVS_ASSERT_NOW(a_no_quad, out_valid && !out_quad_valid, out_corner_a == 16'd0 && out_corner_b == 16'd0 && out_corner_c == 16'd0 && out_corner_d == 16'd0, "corners set without quad")

endmodule

bind uv_sphere_vertex_generator_core uvs_checker u_uvs_checker (.*);

@@ test/uv_sphere_vertex_generator_core_test.sv @@
`timescale 1ns / 1ps

module uv_sphere_vertex_generator_core_test;
  import uvs_pkg::*;

  localparam int          RUN_LIMIT    = 400000;
  localparam int          DRAIN_CYCLES = 60;      // a little over the 36-stage pipe
  localparam int          HOLD_CYCLES  = 300;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;    // no register behind this index
  localparam longint unsigned HALF_PI_Q32  = 64'd6746518852;
  localparam longint unsigned QUARTER      = 64'h4000_0000;
  localparam longint unsigned MASK32       = 64'hFFFF_FFFF;
  localparam longint          ONE_Q30      = 64'sd1 << 30;

  typedef struct {
    logic               point_valid;
    logic signed [16:0] pos_x, pos_z, pos_y;
    logic signed [15:0] norm_x, norm_z, norm_y;
    logic               quad_valid;
    logic [15:0]        corner_a, corner_b, corner_c, corner_d;
  } vertex_t;

  typedef struct {
    logic [7:0] ring;
    logic [7:0] sector;
    bit         off_grid;   // result is known to be all zero
  } grid_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_ring_index = '0;
  logic [7:0]         in_sector_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_point_valid;
  logic signed [16:0] out_pos_first, out_pos_second, out_pos_third;
  logic signed [15:0] out_norm_first, out_norm_second, out_norm_third;
  logic               out_quad_valid;
  logic [15:0]        out_corner_a, out_corner_b, out_corner_c, out_corner_d;
  logic               cfg_wr_en = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  // predictor copy of the registers
  logic [15:0] model_radius = 16'd256;
  logic [8:0]  model_rings = 9'd16;
  logic [8:0]  model_sectors = 9'd16;

  vertex_t vertex_q[$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      hold_arm = 0;
  int      hold_seen = 0;
  int      hold_left = 0;

  uv_sphere_vertex_generator_core DUT (.*);

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // vertex predictor
  // ---------------------------------------------------------------------------

  function automatic longint unsigned grid_count(logic [8:0] c);
    if (c < 2) return 2;
    if (c > 256) return 256;
    return c;
  endfunction

  // taylor sine over a quarter turn, every term truncated, q30 out
  function automatic longint quarter_sin(longint unsigned u);
    longint unsigned x, x2, term;
    longint acc;
    x = (u * HALF_PI_Q32) >> 32;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > ONE_Q30) acc = ONE_Q30;
    return acc;
  endfunction

  // fold a 32-bit phase onto the first quarter turn
  function automatic longint phase_sin(longint unsigned ph);
    longint unsigned quad, f, u;
    longint m;
    quad = (ph & MASK32) >> 30;
    f = ph & (QUARTER - 1);
    u = quad[0] ? QUARTER - f : f;
    m = quarter_sin(u);
    return quad[1] ? -m : m;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    longint unsigned m;
    m = (magnitude(a) * magnitude(b) + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [15:0] q30_to_normal(longint v);
    longint unsigned m;
    longint s;
    m = (magnitude(v) + (64'd1 << (29 - 14))) >> (30 - 14);
    s = (v < 0) ? -longint'(m) : longint'(m);
    return s[15:0];
  endfunction

  function automatic logic signed [16:0] q30_to_position(longint v);
    longint unsigned m;
    longint s;
    m = (magnitude(v) * longint'(model_radius) + (64'd1 << 29)) >> 30;
    s = (v < 0) ? -longint'(m) : longint'(m);
    return s[16:0];
  endfunction

  function automatic vertex_t predict_vertex(logic [7:0] ring, logic [7:0] sector);
    vertex_t v;
    longint unsigned rings, sectors, r, s, theta, phi;
    longint sin_t, sin_p, cos_p, nx, nz, ny;
    v = '{default: '0};
    rings = grid_count(model_rings);
    sectors = grid_count(model_sectors);
    r = ring;
    s = sector;
    if (r >= rings || s >= sectors) return v;
    theta = ((r << 31) + (rings - 1) / 2) / (rings - 1);
    phi = (((s << 32) + (sectors - 1) / 2) / (sectors - 1)) & MASK32;
    sin_t = phase_sin(theta);
    sin_p = phase_sin(phi);
    cos_p = phase_sin((phi + QUARTER) & MASK32);
    nx = mul_q30(cos_p, sin_t);
    nz = mul_q30(sin_p, sin_t);
    ny = phase_sin((theta - QUARTER) & MASK32);
    v.point_valid = 1'b1;
    v.pos_x = q30_to_position(nx);
    v.pos_z = q30_to_position(nz);
    v.pos_y = q30_to_position(ny);
    v.norm_x = q30_to_normal(nx);
    v.norm_z = q30_to_normal(nz);
    v.norm_y = q30_to_normal(ny);
    if (r < rings - 1 && s < sectors - 1) begin
      v.quad_valid = 1'b1;
      v.corner_a = 16'(r * sectors + s);
      v.corner_b = 16'(r * sectors + s + 1);
      v.corner_c = 16'((r + 1) * sectors + s + 1);
      v.corner_d = 16'((r + 1) * sectors + s);
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // output side: stall generation and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
             field, cycle_count, got, want);
    mismatch_count++;
  endtask

  // long hold-off, armed from the stimulus side
  always @(posedge clk) begin
    if (hold_arm != hold_seen) begin
      hold_seen <= hold_arm;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    vertex_t want;
    out_stall <= (hold_left > 1) || ($urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (vertex_q.size() == 0) begin
        report_mismatch("unexpected result transfer", 1, 0);
      end else begin
        want = vertex_q.pop_front();
        if (out_point_valid !== want.point_valid)
          report_mismatch("point_valid", out_point_valid, want.point_valid);
        if (out_pos_first !== want.pos_x) report_mismatch("pos_first", out_pos_first, want.pos_x);
        if (out_pos_second !== want.pos_z)
          report_mismatch("pos_second", out_pos_second, want.pos_z);
        if (out_pos_third !== want.pos_y) report_mismatch("pos_third", out_pos_third, want.pos_y);
        if (out_norm_first !== want.norm_x)
          report_mismatch("norm_first", out_norm_first, want.norm_x);
        if (out_norm_second !== want.norm_z)
          report_mismatch("norm_second", out_norm_second, want.norm_z);
        if (out_norm_third !== want.norm_y)
          report_mismatch("norm_third", out_norm_third, want.norm_y);
        if (out_quad_valid !== want.quad_valid)
          report_mismatch("quad_valid", out_quad_valid, want.quad_valid);
        if (out_corner_a !== want.corner_a) report_mismatch("corner_a", out_corner_a, want.corner_a);
        if (out_corner_b !== want.corner_b) report_mismatch("corner_b", out_corner_b, want.corner_b);
        if (out_corner_c !== want.corner_c) report_mismatch("corner_c", out_corner_c, want.corner_c);
        if (out_corner_d !== want.corner_d) report_mismatch("corner_d", out_corner_d, want.corner_d);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one grid point, return once the transfer has happened;
  // valid stays high so back-to-back points need no extra edge
  task automatic send_point(logic [7:0] ring, logic [7:0] sector, bit off_grid);
    vertex_t want;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_ring_index <= ring;
    in_sector_index <= sector;
    do @(posedge clk); while (in_stall);
    if (off_grid) want = '{default: '0};   // outside the grid everything reads zero
    else want = predict_vertex(ring, sector);
    vertex_q = {vertex_q, want};
  endtask

  // close a phase: lower valid, let every result come back, then let the pipe settle
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_RADIUS:       model_radius = data;
      REG_RING_COUNT:   model_rings = data[8:0];
      REG_SECTOR_COUNT: model_sectors = data[8:0];
      default: ;        // ignored by the block
    endcase
  endtask

  task automatic set_grid(logic [15:0] radius, logic [8:0] rings, logic [8:0] sectors);
    write_reg(REG_RADIUS, radius);
    write_reg(REG_RING_COUNT, {7'd0, rings});
    write_reg(REG_SECTOR_COUNT, {7'd0, sectors});
    cfg_wr_en <= 1'b0;
  endtask

  // mostly points on the grid, some anywhere in the field range
  task automatic send_random(int n);
    int rmax, smax;
    rmax = int'(grid_count(model_rings)) - 1;
    smax = int'(grid_count(model_sectors)) - 1;
    repeat (n) begin
      if ($urandom_range(9) < 8)
        send_point(8'($urandom_range(rmax)), 8'($urandom_range(smax)), 1'b0);
      else
        send_point(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
    end
  endtask

  // mostly small grids, now and then the largest or an out-of-range count
  function automatic logic [8:0] pick_count();
    case ($urandom_range(9))
      0: return 9'd256;
      1: return 9'($urandom_range(1));
      2: return 9'($urandom_range(511, 257));
      default: return 9'($urandom_range(40, 2));
    endcase
  endfunction

  grid_row_t directed_rows[] = '{
    '{8'd0,   8'd0,   1'b0},   // north pole, first quad
    '{8'd15,  8'd15,  1'b0},   // last point: no quad
    '{8'd15,  8'd0,   1'b0},   // last ring: no quad
    '{8'd0,   8'd15,  1'b0},   // last sector: no quad
    '{8'd14,  8'd14,  1'b0},   // last quad
    '{8'd7,   8'd3,   1'b0},
    '{8'd8,   8'd8,   1'b0},
    '{8'd4,   8'd12,  1'b0},
    '{8'd1,   8'd1,   1'b0},
    '{8'd12,  8'd5,   1'b0},
    '{8'd16,  8'd0,   1'b1},   // ring just off the grid
    '{8'd0,   8'd16,  1'b1},   // sector just off the grid
    '{8'd255, 8'd255, 1'b1},   // field maxima
    '{8'd255, 8'd0,   1'b1},
    '{8'd0,   8'd255, 1'b1},
    '{8'd170, 8'd85,  1'b1}
  };

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed points at the reset grid
    foreach (directed_rows[i])
      send_point(directed_rows[i].ring, directed_rows[i].sector, directed_rows[i].off_grid);
    drain_pipe();

    // smallest grid, largest radius
    set_grid(16'hFFFF, 9'd2, 9'd2);
    send_point(8'd0, 8'd0, 1'b0);
    send_point(8'd1, 8'd1, 1'b0);
    send_point(8'd0, 8'd1, 1'b0);
    send_point(8'd1, 8'd0, 1'b0);
    send_point(8'd2, 8'd0, 1'b1);
    drain_pipe();

    // largest grid, zero radius, then corners that reach the top of the index range
    set_grid(16'd0, 9'd256, 9'd256);
    send_point(8'd254, 8'd254, 1'b0);
    send_point(8'd255, 8'd255, 1'b0);
    send_point(8'd128, 8'd64, 1'b0);
    drain_pipe();

    // counts below two and above the maximum, plus a write to no register
    write_reg(REG_RADIUS, 16'h1234);
    write_reg(REG_RING_COUNT, 16'd0);
    write_reg(REG_SECTOR_COUNT, 16'd511);
    write_reg(REG_UNUSED, 16'hFFFF);
    cfg_wr_en <= 1'b0;
    send_random(20);
    drain_pipe();

    // random phases, walking through the idling modes
    for (int phase = 0; phase < 8; phase++) begin
      set_grid(16'($urandom_range(65535)), pick_count(), pick_count());
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      send_random(200);
      drain_pipe();
    end

    // long hold-off while the sender keeps offering, so the pipe backs up
    set_grid(16'($urandom_range(65535)), 9'd32, 9'd32);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_arm = 1;
    send_random(150);
    drain_pipe();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
